// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with no reset qualifier (for checks that must hold in reset).
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== src/ncc_pkg.sv =====
package ncc_pkg;

  localparam int IDX_W   = 6;
  localparam int STAKE_W = 32;
  localparam int COEF_W  = 7;
  localparam int TOTAL_W = 48;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic load_rd;
    logic load_wr;
    logic sel_init;
    logic scan_init;
    logic scan_run;
    logic pick;
    logic emit;
    logic clr_init;
    logic clr_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
    logic total_zero;
    logic scan_done;
    logic best_zero;
    logic passed;
    logic sweep_last;
  } status_t;

endpackage

// ===== src/ncc_ram.sv =====
module ncc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ncc_dp.sv =====
module ncc_dp #(
  parameter int GROUPS   = 64,
  parameter int SUM_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [1:0]                   threshold_thirds,
  input  logic [ncc_pkg::IDX_W-1:0]    group_index,
  input  logic [ncc_pkg::STAKE_W-1:0]  stake_amount,
  input  logic                         last_item,
  input  ncc_pkg::cmd_t                cmd,
  output ncc_pkg::status_t             status,
  output logic [ncc_pkg::COEF_W-1:0]   coefficient,
  output logic [ncc_pkg::TOTAL_W-1:0]  grand_total
);

  localparam int AW = $clog2(GROUPS);
  localparam int CW = $clog2(GROUPS + 1);
  localparam int TW = SUM_BITS + 2;

  logic [1:0]                  thirds_q;
  logic [ncc_pkg::IDX_W-1:0]   idx_q;
  logic [ncc_pkg::STAKE_W-1:0] stake_q;
  logic                        last_q;
  logic                        in_range_q;
  logic [SUM_BITS-1:0]         total;
  logic [SUM_BITS-1:0]         cum;
  logic [CW-1:0]               count;
  logic [TW-1:0]               th;
  logic [SUM_BITS-1:0]         best;
  logic [AW-1:0]               best_addr;
  logic [CW-1:0]               scan_cnt;
  logic                        pend;
  logic [AW-1:0]               rd_addr_q;
  logic [ncc_pkg::COEF_W-1:0]  coef_q;
  logic [ncc_pkg::TOTAL_W-1:0] gtot_q;

  logic [15:0]         idx_ext;
  logic [AW-1:0]       load_addr;
  logic [AW-1:0]       scan_addr;
  logic                issue;
  logic [SUM_BITS-1:0] stake_ext;
  logic [SUM_BITS:0]   grp_raw, tot_raw, cum_raw;
  logic [SUM_BITS-1:0] grp_sum, tot_sum, cum_sum;
  logic [TW-1:0]       cum3;
  logic [15:0]         count_ext;
  logic [63:0]         total_ext;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SUM_BITS-1:0] ram_wdata, ram_rdata;

  ncc_ram #(.WIDTH(SUM_BITS), .DEPTH(GROUPS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_ext   = 16'(idx_q);
  assign load_addr = idx_ext[AW-1:0];
  assign scan_addr = scan_cnt[AW-1:0];
  assign issue     = cmd.scan_run && (scan_cnt != CW'(GROUPS));
  assign stake_ext = SUM_BITS'(stake_q);

  // saturating adds
  assign grp_raw = {1'b0, ram_rdata} + {1'b0, stake_ext};
  assign tot_raw = {1'b0, total} + {1'b0, stake_ext};
  assign cum_raw = {1'b0, cum} + {1'b0, best};
  assign grp_sum = grp_raw[SUM_BITS] ? '1 : grp_raw[SUM_BITS-1:0];
  assign tot_sum = tot_raw[SUM_BITS] ? '1 : tot_raw[SUM_BITS-1:0];
  assign cum_sum = cum_raw[SUM_BITS] ? '1 : cum_raw[SUM_BITS-1:0];

  assign cum3 = {2'b00, cum} + {1'b0, cum, 1'b0};

  assign ram_raddr = cmd.load_rd ? load_addr : scan_addr;

  always_comb begin
    priority if (cmd.load_wr) begin
      ram_we    = in_range_q;
      ram_waddr = load_addr;
      ram_wdata = grp_sum;
    end else if (cmd.pick) begin
      // a picked group is zeroed so later passes skip it
      ram_we    = 1'b1;
      ram_waddr = best_addr;
      ram_wdata = '0;
    end else if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = scan_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = 1'b0;
      ram_waddr = scan_addr;
      ram_wdata = '0;
    end
  end

  assign status.last       = last_q;
  assign status.total_zero = (total == '0);
  assign status.scan_done  = (scan_cnt == CW'(GROUPS)) && !pend;
  assign status.best_zero  = (best == '0);
  assign status.passed     = (cum3 > th);
  assign status.sweep_last = (scan_cnt == CW'(GROUPS - 1));

  assign count_ext   = 16'(count);
  assign total_ext   = 64'(total);
  assign coefficient = coef_q;
  assign grand_total = gtot_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      thirds_q <= 2'd1;
      total    <= '0;
      scan_cnt <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        thirds_q <= threshold_thirds;
      end
      if (cmd.load_wr && in_range_q) begin
        total <= tot_sum;
      end
      if (cmd.scan_init) begin
        scan_cnt <= '0;
        pend     <= 1'b0;
      end else if (cmd.scan_run) begin
        if (issue) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
        pend <= issue;
      end else if (cmd.clr_init) begin
        scan_cnt <= '0;
        total    <= '0;
      end else if (cmd.clr_step) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_q      <= group_index;
      stake_q    <= stake_amount;
      last_q     <= last_item;
      in_range_q <= (32'(group_index) < 32'(GROUPS));
    end
    if (cmd.sel_init) begin
      cum   <= '0;
      count <= '0;
      // thirds of 0 act as 1, 3 as 2: only bit 1 matters
      th    <= thirds_q[1] ? {1'b0, total, 1'b0} : {2'b00, total};
    end else if (cmd.pick) begin
      cum   <= cum_sum;
      count <= count + CW'(1);
    end
    if (cmd.scan_init) begin
      best      <= '0;
      best_addr <= '0;
    end else if (cmd.scan_run) begin
      if (issue) begin
        rd_addr_q <= scan_addr;
      end
      if (pend && (ram_rdata > best)) begin
        best      <= ram_rdata;
        best_addr <= rd_addr_q;
      end
    end
    if (cmd.emit) begin
      coef_q <= count_ext[ncc_pkg::COEF_W-1:0];
      gtot_q <= total_ext[ncc_pkg::TOTAL_W-1:0];
    end
  end

endmodule

// ===== src/ncc_ctrl.sv =====
module ncc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ncc_pkg::status_t status,
  output ncc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_SEL_INIT,
    S_SCAN,
    S_PICK,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD_RD;
        end
      end
      S_LOAD_RD: begin
        cmd.load_rd = 1'b1;
        state_next  = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = status.last ? S_SEL_INIT : S_IDLE;
      end
      S_SEL_INIT: begin
        cmd.sel_init  = 1'b1;
        cmd.scan_init = 1'b1;
        state_next    = status.total_zero ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (status.best_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.pick   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.passed) begin
          state_next = S_EMIT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit     = 1'b1;
          cmd.clr_init = 1'b1;
          state_next   = S_CLEAR;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && !out_ready) || cmd.emit;
    end
  end

endmodule

// ===== src/nakamoto_coefficient_counter.sv =====
// Nakamoto coefficient counter. Each input beat adds stake_amount into the total of
// group_index and into a grand total (both saturating at SUM_BITS). An index at or
// above GROUPS drops the stake. On the beat with last_item set, the block counts how
// many of the largest group totals are needed before 3*cumulative exceeds
// threshold_thirds*grand_total (0 acts as 1, 3 as 2), returns that count with the
// grand total, and clears its table. A zero grand total gives a count of 0.
// Operation: an ordinary beat is accepted, then its group total is read and then
// written back (read-modify-write on the single group RAM). A last beat then adds a
// selection in which each pick is one full scan of the RAM for the largest
// remaining total; after the result is loaded, a clearing sweep over all GROUPS
// entries runs before the next beat is taken. The same sweep runs after reset.
// The result sits in an output register and need not be taken before the sweep.
module nakamoto_coefficient_counter_unit #(
  parameter int GROUPS   = 64,
  parameter int SUM_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [1:0]                   threshold_thirds,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ncc_pkg::IDX_W-1:0]    group_index,
  input  logic [ncc_pkg::STAKE_W-1:0]  stake_amount,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ncc_pkg::COEF_W-1:0]   coefficient,
  output logic [ncc_pkg::TOTAL_W-1:0]  grand_total
);

  ncc_pkg::cmd_t    cmd;
  ncc_pkg::status_t status;

  ncc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ncc_dp #(.GROUPS(GROUPS), .SUM_BITS(SUM_BITS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .threshold_thirds (threshold_thirds),
    .group_index      (group_index),
    .stake_amount     (stake_amount),
    .last_item        (last_item),
    .cmd              (cmd),
    .status           (status),
    .coefficient      (coefficient),
    .grand_total      (grand_total)
  );

endmodule

// ===== src/ncc_checker.sv =====
`include "assert_macros.svh"

module ncc_checker #(
  parameter int GROUPS   = 64,
  parameter int SUM_BITS = 48
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ncc_pkg::COEF_W-1:0]   coefficient,
  input logic [ncc_pkg::TOTAL_W-1:0]  grand_total
);

  // stalled result beat holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(coefficient) && $stable(grand_total)),
    "result beat changed while stalled")

  // reset starts the clearing sweep with nothing pending
  `ASSERT_CLK(a_reset_sweep, clk, (rst |=> (!in_ready && !out_valid)),
    "block ready or result valid right after reset")

  // an accepted beat is worked on before the next is taken
  `ASSERT_CLK_RST(a_one_at_a_time, clk, rst, (in_valid && in_ready) |=> !in_ready,
    "input taken on back-to-back cycles")

  // the count never exceeds the number of groups
  `ASSERT_CLK_RST(a_coef_range, clk, rst, out_valid |-> (32'(coefficient) <= GROUPS),
    "coefficient above group count")

  // an empty set gives a zero count (checked only where SUM_BITS fits the 48-bit output total)
  `ASSERT_CLK_RST(a_zero_total, clk, rst,
    (out_valid && (grand_total == '0)) |->
      ((coefficient == '0) || (SUM_BITS > ncc_pkg::TOTAL_W)),
    "nonzero count for zero total")

endmodule

bind nakamoto_coefficient_counter_unit ncc_checker #(
  .GROUPS(GROUPS),
  .SUM_BITS(SUM_BITS)
) u_checker (.*);
